>>> hdl/gate_flag_mask_editor_core_assert.svh
// Assertion macros shared by the gate flag mask editor RTL.
`ifndef GATE_FLAG_MASK_EDITOR_CORE_ASSERT_SVH
`define GATE_FLAG_MASK_EDITOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define GFME_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("gfme assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define GFME_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("gfme assertion failed");

`endif

>>> hdl/gfme_pkg.sv
// Types and constants of the gate flag mask editor.
package gfme_pkg;

    localparam int DEF_GATE_DEPTH = 2048;

    localparam int GATE_W   = 11;
    localparam int SAMPLE_W = 16;
    localparam int TDATA_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [23:0] SAMPLE_MAX = 24'sd32767;
    localparam logic signed [23:0] SAMPLE_MIN = -24'sd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_OP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMP_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_CONST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd6;

    localparam logic signed [SAMPLE_W-1:0] BAD_VALUE_RST = -16'sd32768;
    localparam logic signed [SAMPLE_W-1:0] GAIN_RST      = 16'sd256;

    typedef enum logic [3:0] {
        OP_SET        = 4'd0,
        OP_AND        = 4'd1,
        OP_OR         = 4'd2,
        OP_XOR        = 4'd3,
        OP_COPY       = 4'd4,
        OP_COMPLEMENT = 4'd5,
        OP_CLEAR      = 4'd6,
        OP_ASSERT     = 4'd7,
        OP_ADD        = 4'd8,
        OP_MULTIPLY   = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        CMP_BELOW   = 2'd0,
        CMP_ABOVE   = 2'd1,
        CMP_BETWEEN = 2'd2
    } t_cmp;

    typedef enum logic [1:0] {
        EDIT_NONE = 2'd0,
        EDIT_BAD  = 2'd1,
        EDIT_ADD  = 2'd2,
        EDIT_MUL  = 2'd3
    } t_edit;

endpackage

>>> hdl/gate_flag_mask_editor_core.sv
// Gate flag mask editor: per-gate flag store with threshold, copy and sample edits.
// A request goes through stage A, stage B and the output register to m_tvalid.
// Throughput: one gate per cycle while neither m_tready nor a clearing pass stalls it;
// the flag store read-modify-write is closed by a bypass. Reset (synchronous, active
// low) clears the pipeline and starts a clearing pass over the whole flag store with
// s_tready low; configuration writes are taken. Registers return to their reset values.
module gate_flag_mask_editor_core #(
    parameter int GATE_DEPTH = gfme_pkg::DEF_GATE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [gfme_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gfme_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Gate requests in.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gfme_pkg::TDATA_W-1:0]      s_tdata,   // gate_index[10:0], sample[26:11]
    input  logic                              s_tuser,   // in_boundary[0]
    // Edited gates out.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gfme_pkg::TDATA_W-1:0]      m_tdata,   // gate_out[10:0], value_out[26:11]
    output logic                              m_tuser    // flag_out[0]
);
    import gfme_pkg::*;

    `include "gate_flag_mask_editor_core_assert.svh"

    localparam int AW = (GATE_DEPTH > 1) ? $clog2(GATE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(GATE_DEPTH - 1);

    // Configuration registers.
    t_op                         r_op;
    t_cmp                        r_cmp_mode;
    logic signed [SAMPLE_W-1:0]  r_thr_low;
    logic signed [SAMPLE_W-1:0]  r_thr_high;
    logic signed [SAMPLE_W-1:0]  r_bad_value;
    logic signed [SAMPLE_W-1:0]  r_add_const;
    logic signed [SAMPLE_W-1:0]  r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_SET;
            r_cmp_mode  <= CMP_BELOW;
            r_thr_low   <= '0;
            r_thr_high  <= '0;
            r_bad_value <= BAD_VALUE_RST;
            r_add_const <= '0;
            r_gain      <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OP:        r_op        <= t_op'(i_cfg_data[3:0]);
                CFG_CMP_MODE:  r_cmp_mode  <= t_cmp'(i_cfg_data[1:0]);
                CFG_THR_LOW:   r_thr_low   <= i_cfg_data;
                CFG_THR_HIGH:  r_thr_high  <= i_cfg_data;
                CFG_BAD_VALUE: r_bad_value <= i_cfg_data;
                CFG_ADD_CONST: r_add_const <= i_cfg_data;
                CFG_GAIN:      r_gain      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input unpacking.
    logic [GATE_W-1:0]          in_gate;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [AW-1:0]              in_addr;
    logic                       in_inrange;

    assign in_gate    = s_tdata[GATE_W-1:0];
    assign in_sample  = s_tdata[GATE_W+SAMPLE_W-1:GATE_W];
    assign in_addr    = AW'(in_gate);
    assign in_inrange = (32'(in_gate) < 32'(GATE_DEPTH));

    // Pipeline control.
    logic r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic r_a_valid, r_b_valid, r_o_valid;
    logic out_ready, b_ready, a_ready, accept, a_move, b_move;

    assign out_ready = !r_o_valid || m_tready;
    assign b_ready   = !r_b_valid || out_ready;
    assign a_ready   = !r_a_valid || b_ready;
    assign s_tready  = a_ready && !r_clr_busy;
    assign accept    = s_tvalid && s_tready;
    assign a_move    = r_a_valid && b_ready;
    assign b_move    = r_b_valid && out_ready;

    // Stage A: request registered, flag entry read from the store.
    logic [GATE_W-1:0]          r_a_gate;
    logic signed [SAMPLE_W-1:0] r_a_sample;
    logic                       r_a_bnd;
    logic                       r_a_inrange;
    logic                       r_a_hit;
    logic                       r_a_hitflag;
    logic                       r_rd;
    logic                       r_mem [GATE_DEPTH];

    logic                       n_flag;
    logic [AW-1:0]              mem_addr;
    logic                       mem_we;
    logic                       mem_wdata;

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = 1'b0;
        end else begin
            mem_we    = a_move && r_a_inrange;
            mem_addr  = AW'(r_a_gate);
            mem_wdata = n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (accept) begin
            r_rd <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_hit   <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                // The store read misses a write to the same gate on this edge.
                r_a_hit   <= a_move && r_a_inrange && (r_a_gate == in_gate);
            end else if (a_move) begin
                r_a_valid <= 1'b0;
                r_a_hit   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_gate    <= in_gate;
            r_a_sample  <= in_sample;
            r_a_bnd     <= s_tuser;
            r_a_inrange <= in_inrange;
            r_a_hitflag <= n_flag;
        end
    end

    // Flag update, edit decision, product and sum, side by side.
    logic  f_old, smp_ok, cmp_hit;
    t_edit n_edit;
    logic signed [31:0]         n_prod;
    logic signed [SAMPLE_W-1:0] n_sum;

    assign f_old  = r_a_inrange && (r_a_hit ? r_a_hitflag : r_rd);
    assign smp_ok = (r_a_sample != r_bad_value);
    assign n_prod = 32'(r_a_sample) * 32'(r_gain);
    assign n_sum  = r_a_sample + r_add_const;

    always_comb begin
        unique case (r_cmp_mode)
            CMP_BELOW: cmp_hit = (r_a_sample < r_thr_low);
            CMP_ABOVE: cmp_hit = (r_a_sample > r_thr_low);
            default:   cmp_hit = (r_a_sample >= r_thr_low) && (r_a_sample <= r_thr_high);
        endcase
    end

    always_comb begin
        n_flag = f_old;
        n_edit = EDIT_NONE;
        unique case (r_op)
            OP_SET: n_flag = r_a_bnd && smp_ok && cmp_hit;
            OP_AND: begin
                if (r_a_bnd) begin
                    n_flag = smp_ok && f_old && cmp_hit;
                end
            end
            OP_OR: begin
                if (r_a_bnd && smp_ok) begin
                    n_flag = f_old || cmp_hit;
                end
            end
            OP_XOR: begin
                if (r_a_bnd && smp_ok) begin
                    n_flag = f_old ^ cmp_hit;
                end
            end
            OP_COPY: begin
                if (r_a_bnd) begin
                    n_flag = !smp_ok;
                end
            end
            OP_COMPLEMENT: n_flag = !f_old;
            OP_CLEAR:      n_flag = 1'b0;
            OP_ASSERT: begin
                if (r_a_bnd && f_old) begin
                    n_edit = EDIT_BAD;
                end
            end
            OP_ADD: begin
                if (r_a_bnd && smp_ok && f_old) begin
                    n_edit = EDIT_ADD;
                end
            end
            OP_MULTIPLY: begin
                if (r_a_bnd && smp_ok && f_old) begin
                    n_edit = EDIT_MUL;
                end
            end
            default: begin
            end
        endcase
    end

    // Stage B: new flag, edit kind, product and sum.
    logic [GATE_W-1:0]          r_b_gate;
    logic signed [SAMPLE_W-1:0] r_b_sample;
    logic signed [SAMPLE_W-1:0] r_b_sum;
    logic signed [31:0]         r_b_prod;
    logic                       r_b_flag;
    t_edit                      r_b_edit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_gate   <= r_a_gate;
            r_b_sample <= r_a_sample;
            r_b_sum    <= n_sum;
            r_b_prod   <= n_prod;
            r_b_flag   <= n_flag;
            r_b_edit   <= n_edit;
        end
    end

    // Divide the Q8.8 product by 256 toward zero, then saturate.
    logic signed [31:0]         prod_adj;
    logic signed [23:0]         prod_q;
    logic signed [SAMPLE_W-1:0] prod_sat;
    logic signed [SAMPLE_W-1:0] n_value;

    assign prod_adj = r_b_prod + (r_b_prod[31] ? 32'sd255 : 32'sd0);
    assign prod_q   = prod_adj[31:8];

    always_comb begin
        if (prod_q > SAMPLE_MAX) begin
            prod_sat = SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (prod_q < SAMPLE_MIN) begin
            prod_sat = SAMPLE_MIN[SAMPLE_W-1:0];
        end else begin
            prod_sat = prod_q[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        unique case (r_b_edit)
            EDIT_BAD: n_value = r_bad_value;
            EDIT_ADD: n_value = r_b_sum;
            EDIT_MUL: n_value = prod_sat;
            default:  n_value = r_b_sample;
        endcase
    end

    // Output register.
    logic [GATE_W-1:0]          r_o_gate;
    logic signed [SAMPLE_W-1:0] r_o_value;
    logic                       r_o_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_o_gate  <= r_b_gate;
            r_o_value <= n_value;
            r_o_flag  <= r_b_flag;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {(TDATA_W - GATE_W - SAMPLE_W)'(0), r_o_value, r_o_gate};
    assign m_tuser  = r_o_flag;

    // The clearing pass runs only with an empty pipeline and no request taken.
    `GFME_ASSERT_IMP(a_clr_empty, r_clr_busy, !s_tready && !r_a_valid && !r_b_valid && !r_o_valid)
    // A bypass hit belongs to a request held in stage A.
    `GFME_ASSERT_IMP(a_hit_valid, r_a_hit, r_a_valid)
    // A sample edit only happens on a flagged gate.
    `GFME_ASSERT_IMP(a_edit_flag, r_b_valid && (r_b_edit != EDIT_NONE), r_b_flag)
    // A stalled stage B keeps its gate.
    `GFME_ASSERT_NXT(a_b_hold, r_b_valid && !out_ready, r_b_valid && $stable(r_b_gate))

endmodule
